// File: hdl/mlfls_pkg.sv
// Shared types and constants for the length-prefixed frame log splitter.
// Used by mlfls_core, mlfls_out_queue and the top level; no dependencies.
package mlfls_pkg;

	// Frame size cap, header included
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int HEADER_BYTES    = 8;
	localparam int LIMIT_CAP       = MAX_FRAME_BYTES - HEADER_BYTES;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_LEN_W  = 12;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 12'd4088;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 1'd1;

	// Error codes carried with each result
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MAGIC  = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;

	// Delimiter characters
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_AT   = 8'h40;

	// One byte can cause at most this many results
	localparam int BATCH_MAX = 4;

	typedef struct packed {
		logic [7:0] log_byte;
		logic       byte_valid;
		logic       end_of_log;
		logic [1:0] frame_error;
	} res_t;

	// Results caused by one input byte; cnt of zero means none
	typedef struct packed {
		res_t [BATCH_MAX-1:0] res;
		logic [2:0]           cnt;
	} batch_t;

endpackage

// File: hdl/magic_length_frame_log_splitter.sv
// Top level of the length-prefixed frame log splitter.
// Depends on mlfls_pkg, mlfls_core and mlfls_out_queue.
//
// Usage:
//   The slave side takes the received stream, one byte per beat on s_tdata.
//   Each frame is a 4-byte magic word, a 4-byte little-endian length, then
//   the payload. The master side gives log results, one per beat: a log
//   byte, an end-of-log mark on tlast, an error code and a mark on the
//   last result that a given input byte caused.
//   Configuration (frame_magic at index 0, max_payload_len at index 1) is
//   written through cfg_we/cfg_index/cfg_wdata while the block is idle.
//   Results of a byte are registered in the queue before reaching the
//   master side. Throughput: one input byte per cycle while s_tready is
//   high; a byte causes zero to four results, sent at one per cycle while
//   m_tready is high from a two-batch queue, so s_tready drops only while
//   two batches are waiting. When the receiver stalls, the queue holds its
//   results and keeps taking bytes until both batch slots are full.
//   Reset clears the frame state and queue and restores max_payload_len to
//   4088 and frame_magic to zero; the block then hunts for a header.
module magic_length_frame_log_splitter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mlfls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // [7:0] data_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // [7:0] log_byte, [8] last_result
	output logic [2:0]                        m_tuser,   // [0] byte_valid, [2:1] frame_error
	output logic                              m_tlast    // end_of_log
);
	import mlfls_pkg::*;

	logic   accept;
	logic   space;
	batch_t batch;

	// Accept a beat whenever a batch slot is free
	assign s_tready = space;
	assign accept   = s_tvalid && space;

	mlfls_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_accept (accept),
		.in_byte   (s_tdata),
		.batch     (batch)
	);

	mlfls_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && (batch.cnt != 3'd0)),
		.batch    (batch),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: hdl/mlfls_core.sv
// Deframer core: configuration registers, header/payload state, and the
// per-byte logic that builds the batch of results. Depends on mlfls_pkg.
module mlfls_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mlfls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              in_accept,
	input  logic [7:0]                        in_byte,
	output mlfls_pkg::batch_t                 batch
);
	import mlfls_pkg::*;

	localparam logic [1:0] PH_MAGIC   = 2'd0;
	localparam logic [1:0] PH_LEN     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [31:0]          magic_q;
	logic [MAX_LEN_W-1:0] max_len_q;

	logic [1:0]  phase_q, phase_n;
	logic [2:0]  hcount_q, hcount_n;
	logic [31:0] hshift_q, hshift_n;
	logic [12:0] remain_q, remain_n;
	logic [1:0]  dmatch_q, dmatch_n;
	logic [7:0]  held0_q, held0_n, held1_q, held1_n;
	logic        past_q, past_n;
	logic        zseen_q, zseen_n;
	logic [31:0] limit;

	function automatic batch_t put_res(batch_t b, logic [7:0] data, logic valid,
		logic eol, logic [1:0] err);
		batch_t r;
		r = b;
		r.res[b.cnt[1:0]].log_byte    = data;
		r.res[b.cnt[1:0]].byte_valid  = valid;
		r.res[b.cnt[1:0]].end_of_log  = eol;
		r.res[b.cnt[1:0]].frame_error = err;
		r.cnt = b.cnt + 3'd1;
		return r;
	endfunction

	// Emit held partial-delimiter bytes, optionally closing the segment
	function automatic batch_t flush_held(batch_t b, logic [1:0] dm, logic [7:0] h0,
		logic [7:0] h1, logic past, logic mark_end);
		batch_t     r;
		logic [1:0] k;
		r = b;
		k = (dm == 2'd3) ? 2'd2 : dm;
		if (past) begin
			if (k != 2'd0)
				r = put_res(r, h0, 1'b1, mark_end && (k == 2'd1), ERR_NONE);
			if (k == 2'd2)
				r = put_res(r, h1, 1'b1, mark_end, ERR_NONE);
			if (mark_end && (k == 2'd0))
				r = put_res(r, 8'd0, 1'b0, 1'b1, ERR_NONE);
		end
		return r;
	endfunction

	// Effective length limit: configured value capped at the frame size less the header
	assign limit = ({20'd0, max_len_q} > 32'(LIMIT_CAP)) ? 32'(LIMIT_CAP)
		: {20'd0, max_len_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_MAGIC: magic_q   <= cfg_wdata;
				REG_MAX_LEN:     max_len_q <= cfg_wdata[MAX_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-byte next state and results
	always_comb begin : step
		logic [1:0] k;
		logic [7:0] dch;
		logic       start;
		batch_t     b;
		b        = '0;
		start    = 1'b0;
		k        = 2'd0;
		dch      = CH_HASH;
		phase_n  = phase_q;
		hcount_n = hcount_q;
		hshift_n = hshift_q;
		remain_n = remain_q;
		dmatch_n = dmatch_q;
		held0_n  = held0_q;
		held1_n  = held1_q;
		past_n   = past_q;
		zseen_n  = zseen_q;

		if (phase_q == PH_PAYLOAD) begin
			if (!zseen_q) begin
				if (in_byte == 8'd0) begin
					b        = flush_held(b, dmatch_n, held0_n, held1_n, past_n, 1'b1);
					dmatch_n = 2'd0;
					zseen_n  = 1'b1;
				end else begin
					k        = (dmatch_n == 2'd3) ? 2'd0 : dmatch_n;
					dmatch_n = k;
					dch      = (k == 2'd1) ? CH_AT : CH_HASH;
					if (in_byte == dch) begin
						if (k == 2'd2) begin
							if (past_n)
								b = put_res(b, 8'd0, 1'b0, 1'b1, ERR_NONE);
							past_n   = 1'b1;
							dmatch_n = 2'd0;
						end else begin
							if (k == 2'd0)
								held0_n = in_byte;
							else
								held1_n = in_byte;
							dmatch_n = k + 2'd1;
						end
					end else begin
						b        = flush_held(b, dmatch_n, held0_n, held1_n, past_n, 1'b0);
						dmatch_n = 2'd0;
						if (in_byte == CH_HASH) begin
							held0_n  = in_byte;
							dmatch_n = 2'd1;
						end else if (past_n) begin
							b = put_res(b, in_byte, 1'b1, 1'b0, ERR_NONE);
						end
					end
				end
			end
			remain_n = remain_q - 13'd1;
			if (remain_n == 13'd0) begin
				if (!zseen_n)
					b = flush_held(b, dmatch_n, held0_n, held1_n, past_n, 1'b1);
				phase_n = PH_MAGIC;
				start   = 1'b1;
			end
		end else begin
			phase_n  = (phase_q == PH_LEN) ? PH_LEN : PH_MAGIC;
			hshift_n = {in_byte, hshift_q[31:8]};
			hcount_n = hcount_q + 3'd1;
			if (hcount_n[2]) begin
				hcount_n = 3'd0;
				hshift_n = '0;
				if (phase_n == PH_MAGIC) begin
					if ({in_byte, hshift_q[31:8]} == magic_q) begin
						phase_n = PH_LEN;
					end else begin
						b     = put_res(b, 8'd0, 1'b0, 1'b0, ERR_MAGIC);
						start = 1'b1;
					end
				end else begin
					if ({in_byte, hshift_q[31:8]} > limit) begin
						b       = put_res(b, 8'd0, 1'b0, 1'b0, ERR_LENGTH);
						phase_n = PH_MAGIC;
						start   = 1'b1;
					end else if ({in_byte, hshift_q[31:8]} == 32'd0) begin
						phase_n = PH_MAGIC;
						start   = 1'b1;
					end else begin
						start    = 1'b1;
						remain_n = hshift_q[20:8];
						phase_n  = PH_PAYLOAD;
					end
				end
			end
		end

		// Clear per-frame state
		if (start) begin
			hcount_n = 3'd0;
			hshift_n = '0;
			dmatch_n = 2'd0;
			held0_n  = 8'd0;
			held1_n  = 8'd0;
			past_n   = 1'b0;
			zseen_n  = 1'b0;
		end
		batch = b;
	end

	// Advance state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			hcount_q <= '0;
			hshift_q <= '0;
			remain_q <= '0;
			dmatch_q <= '0;
			held0_q  <= '0;
			held1_q  <= '0;
			past_q   <= 1'b0;
			zseen_q  <= 1'b0;
		end else if (in_accept) begin
			phase_q  <= phase_n;
			hcount_q <= hcount_n;
			hshift_q <= hshift_n;
			remain_q <= remain_n;
			dmatch_q <= dmatch_n;
			held0_q  <= held0_n;
			held1_q  <= held1_n;
			past_q   <= past_n;
			zseen_q  <= zseen_n;
		end
	end

endmodule

// File: hdl/mlfls_out_queue.sv
// Two-entry result batch queue with a serializer that sends one result
// per output beat. Depends on mlfls_pkg.
module mlfls_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mlfls_pkg::batch_t batch,
	output logic              space,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [7:0] log_byte, [8] last_result
	output logic [2:0]        m_tuser,   // [0] byte_valid, [2:1] frame_error
	output logic              m_tlast
);
	import mlfls_pkg::*;

	batch_t     ent_q [2];
	logic [1:0] count_q;
	logic       rd_ptr_q;
	logic [1:0] idx_q;
	logic       wr_ptr;
	batch_t     head;
	res_t       cur;
	logic       last;
	logic       beat;
	logic       pop;

	assign space    = (count_q != 2'd2);
	assign wr_ptr   = rd_ptr_q ^ count_q[0];
	assign head     = ent_q[rd_ptr_q];
	assign cur      = head.res[idx_q];
	assign last     = (({1'b0, idx_q} + 3'd1) == head.cnt);
	assign m_tvalid = (count_q != 2'd0);
	assign beat     = m_tvalid && m_tready;
	assign pop      = beat && last;

	assign m_tdata = {7'd0, last, cur.log_byte};
	assign m_tuser = {cur.frame_error, cur.byte_valid};
	assign m_tlast = cur.end_of_log;

	// Store incoming batch
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr] <= batch;
	end

	// Track fill level and position inside the head batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= '0;
			end else if (beat) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
